FILE: sv/tmo_pkg.sv
`timescale 1ns / 1ps

package tmo_pkg;

    // Default sizing of the block.
    localparam int MAX_LEVELS_DEF = 15;
    localparam int DIM_BITS_DEF   = 15;

    // Field widths of the streams.
    localparam int LEVEL_W  = 4;
    localparam int FACE_W   = 3;
    localparam int OFFSET_W = 48;
    localparam int BYTES_W  = 45;
    localparam int KIND_W   = 2;
    localparam int FMT_W    = 3;
    localparam int COUNT_W  = 4;

    // Saturation limits of the result fields.
    localparam logic [63:0] OFFSET_MAX = (64'd1 << OFFSET_W) - 64'd1;
    localparam logic [63:0] BYTES_MAX  = (64'd1 << BYTES_W) - 64'd1;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_FMT    = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DEPTH  = 3'd4;
    localparam logic [2:0] REG_COUNT  = 3'd5;

    // Texture kinds.
    localparam logic [KIND_W-1:0] KIND_FLAT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CUBE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VOLUME = 2'd2;

    // Pixel formats.
    localparam logic [FMT_W-1:0] FMT_RGBA8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_R5G6B5 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_DXT1   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_DXT3   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_DXT5   = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIMS,
        ST_MUL1,
        ST_MUL2,
        ST_SCALE,
        ST_FACE,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic dims;
        logic mul1;
        logic mul2;
        logic scale;
        logic face;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_level;
        logic out_busy;
    } stat_t;

    // Log2 of the bytes per pixel or per 4x4 block.
    function automatic logic [2:0] fmt_shift(input logic [FMT_W-1:0] fmt);
        logic [2:0] sh;
        case (fmt)
            FMT_RGBA8:  sh = 3'd2;
            FMT_R5G6B5: sh = 3'd1;
            FMT_DXT1:   sh = 3'd3;
            FMT_DXT3:   sh = 3'd4;
            FMT_DXT5:   sh = 3'd4;
            default:    sh = 3'd0;
        endcase
        return sh;
    endfunction

    function automatic logic fmt_known(input logic [FMT_W-1:0] fmt);
        return fmt inside {FMT_RGBA8, FMT_R5G6B5, FMT_DXT1, FMT_DXT3, FMT_DXT5};
    endfunction

    function automatic logic fmt_block(input logic [FMT_W-1:0] fmt);
        return fmt inside {FMT_DXT1, FMT_DXT3, FMT_DXT5};
    endfunction

endpackage

FILE: sv/tmo_cfg_regs.sv
`timescale 1ns / 1ps

module tmo_cfg_regs import tmo_pkg::*; #(
    parameter int DIM_BITS = DIM_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic [KIND_W-1:0]    cfg_kind,
    output logic [FMT_W-1:0]     cfg_fmt,
    output logic [DIM_BITS-1:0]  cfg_width,
    output logic [DIM_BITS-1:0]  cfg_height,
    output logic [DIM_BITS-1:0]  cfg_depth,
    output logic [COUNT_W-1:0]   cfg_count
);

    logic [KIND_W-1:0]   kind_reg;
    logic [FMT_W-1:0]    fmt_reg;
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic [DIM_BITS-1:0] depth_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                wr_en;
    logic [2:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= KIND_FLAT;
            fmt_reg    <= FMT_RGBA8;
            width_reg  <= DIM_BITS'(1);
            height_reg <= DIM_BITS'(1);
            depth_reg  <= DIM_BITS'(1);
            count_reg  <= COUNT_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_KIND:   kind_reg   <= pwdata[KIND_W-1:0];
                REG_FMT:    fmt_reg    <= pwdata[FMT_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
                REG_DEPTH:  depth_reg  <= pwdata[DIM_BITS-1:0];
                REG_COUNT:  count_reg  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        case (reg_idx)
            REG_KIND:   prdata = 32'(kind_reg);
            REG_FMT:    prdata = 32'(fmt_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_DEPTH:  prdata = 32'(depth_reg);
            REG_COUNT:  prdata = 32'(count_reg);
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg_kind   = kind_reg;
    assign cfg_fmt    = fmt_reg;
    assign cfg_width  = width_reg;
    assign cfg_height = height_reg;
    assign cfg_depth  = depth_reg;
    assign cfg_count  = count_reg;

endmodule

FILE: sv/tmo_ctrl.sv
`timescale 1ns / 1ps

module tmo_ctrl import tmo_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  s_tready
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: four steps per mip level, then the face term and the output load.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_DIMS;
            ST_DIMS:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_SCALE;
            ST_SCALE: state_next = stat.last_level ? ST_FACE : ST_DIMS;
            ST_FACE:  state_next = ST_LOAD;
            ST_LOAD:  if (!stat.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:  cmd.accept = s_tvalid;
            ST_DIMS:  cmd.dims   = 1'b1;
            ST_MUL1:  cmd.mul1   = 1'b1;
            ST_MUL2:  cmd.mul2   = 1'b1;
            ST_SCALE: cmd.scale  = 1'b1;
            ST_FACE:  cmd.face   = 1'b1;
            ST_LOAD:  cmd.load   = !stat.out_busy;
            default:  cmd = '0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

FILE: sv/tmo_dpath.sv
`timescale 1ns / 1ps

module tmo_dpath import tmo_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [LEVEL_W-1:0]   in_level,
    input  logic [FACE_W-1:0]    in_face,
    input  logic [KIND_W-1:0]    cfg_kind,
    input  logic [FMT_W-1:0]     cfg_fmt,
    input  logic [DIM_BITS-1:0]  cfg_width,
    input  logic [DIM_BITS-1:0]  cfg_height,
    input  logic [DIM_BITS-1:0]  cfg_depth,
    input  logic [COUNT_W-1:0]   cfg_count,
    input  logic                 m_tready,
    output logic                 out_valid,
    output logic [OFFSET_W-1:0]  byte_offset,
    output logic [BYTES_W-1:0]   level_bytes,
    output logic                 level_present
);

    localparam int PROD1_W = 2 * DIM_BITS;
    localparam int PROD2_W = 3 * DIM_BITS;
    localparam int SIZE_W  = 3 * DIM_BITS + 4;
    localparam int ACC_W   = 3 * DIM_BITS + 12;

    logic [LEVEL_W-1:0]  level_reg;
    logic [FACE_W-1:0]   face_reg;
    logic [LEVEL_W-1:0]  idx_reg;
    logic [DIM_BITS-1:0] w_reg;
    logic [DIM_BITS-1:0] h_reg;
    logic [DIM_BITS-1:0] d_reg;
    logic [PROD1_W-1:0]  prod1_reg;
    logic [PROD2_W-1:0]  prod2_reg;
    logic [SIZE_W-1:0]   cur_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic                present_reg;

    logic                blk;
    logic                cube;
    logic                idx_exists;
    logic                lvl_exists;
    logic [SIZE_W-1:0]   size_c;
    logic [ACC_W-1:0]    size_ext;
    logic [SIZE_W+2:0]   face_prod;
    logic [63:0]         acc_wide;
    logic [63:0]         cur_wide;

    // Dimension of one level: shift, floor of one, and 4x4 block count if compressed.
    function automatic logic [DIM_BITS-1:0] lvl_dim(input logic [DIM_BITS-1:0] base,
                                                    input logic [LEVEL_W-1:0]  sh,
                                                    input logic                is_blk);
        logic [DIM_BITS-1:0] v;
        logic [DIM_BITS:0]   r;
        v = base >> sh;
        if (v == '0) begin
            v = DIM_BITS'(1);
        end
        r = {1'b0, v} + (DIM_BITS + 1)'(3);
        if (is_blk) begin
            v = DIM_BITS'(r[DIM_BITS:2]);
        end
        return v;
    endfunction

    assign blk  = fmt_block(cfg_fmt);
    assign cube = (cfg_kind == KIND_CUBE);

    assign idx_exists = (idx_reg < cfg_count) && ({1'b0, idx_reg} < 5'(MAX_LEVELS));
    assign lvl_exists = (level_reg < cfg_count) && ({1'b0, level_reg} < 5'(MAX_LEVELS));

    // Byte size of the level under work; zero when absent or of unknown kind or format.
    always_comb begin
        if (idx_exists && (cfg_kind inside {KIND_FLAT, KIND_CUBE, KIND_VOLUME})
                && fmt_known(cfg_fmt)) begin
            size_c = SIZE_W'(prod2_reg) << fmt_shift(cfg_fmt);
        end else begin
            size_c = '0;
        end
    end

    assign size_ext  = ACC_W'(size_c);
    assign face_prod = (SIZE_W + 3)'(cur_reg) * (SIZE_W + 3)'(face_reg);

    // Query capture and per-level loop over the shared multiplier stages.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            level_reg <= in_level;
            face_reg  <= in_face;
            idx_reg   <= '0;
            acc_reg   <= '0;
        end
        if (cmd.dims) begin
            w_reg <= lvl_dim(cfg_width, idx_reg, blk);
            h_reg <= lvl_dim(cfg_height, idx_reg, blk);
            d_reg <= lvl_dim(cfg_depth, idx_reg, blk);
        end
        if (cmd.mul1) begin
            prod1_reg <= PROD1_W'(w_reg) * PROD1_W'(cube ? w_reg : h_reg);
        end
        if (cmd.mul2) begin
            prod2_reg <= PROD2_W'(prod1_reg)
                         * PROD2_W'((cfg_kind == KIND_VOLUME) ? d_reg : DIM_BITS'(1));
        end
        if (cmd.scale) begin
            idx_reg <= idx_reg + LEVEL_W'(1);
            if (idx_reg == level_reg) begin
                cur_reg <= size_c;
            end else if (cube) begin
                acc_reg <= acc_reg + (size_ext << 2) + (size_ext << 1);
            end else begin
                acc_reg <= acc_reg + size_ext;
            end
        end
        if (cmd.face && cube) begin
            acc_reg <= acc_reg + ACC_W'(face_prod);
        end
    end

    assign acc_wide = 64'(acc_reg);
    assign cur_wide = 64'(cur_reg);

    // Output register with saturation of both sizes.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            offset_reg  <= (acc_wide > OFFSET_MAX) ? OFFSET_MAX[OFFSET_W-1:0]
                                                   : acc_wide[OFFSET_W-1:0];
            bytes_reg   <= (cur_wide > BYTES_MAX) ? BYTES_MAX[BYTES_W-1:0]
                                                  : cur_wide[BYTES_W-1:0];
            present_reg <= lvl_exists;
        end
    end

    // Result valid flag: set on load, cleared once the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.last_level = (idx_reg == level_reg);
    assign stat.out_busy   = out_valid_reg & ~m_tready;

    assign out_valid     = out_valid_reg;
    assign byte_offset   = offset_reg;
    assign level_bytes   = bytes_reg;
    assign level_present = present_reg;

endmodule

FILE: sv/texture_mip_offset_calc.sv
`timescale 1ns / 1ps
// Each mip level up to the one asked for takes four steps through the shared
// dimension, two-multiplier and scale datapath; the face term and output load are two
// further steps, and the load waits while an earlier result is not yet taken.
// A new query is accepted only in idle, once the previous one has been loaded.
// Reset: aresetn is synchronous and active low; it returns the controller to idle,
// drops the result valid and loads the configuration registers with their defaults.

module texture_mip_offset_calc import tmo_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Query stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] level, [6:4] face, [7] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [47:0] byte_offset, [92:48] level_bytes,
                                   // [93] level_present, [95:94] zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t                cmd;
    stat_t               stat;
    logic [KIND_W-1:0]   cfg_kind;
    logic [FMT_W-1:0]    cfg_fmt;
    logic [DIM_BITS-1:0] cfg_width;
    logic [DIM_BITS-1:0] cfg_height;
    logic [DIM_BITS-1:0] cfg_depth;
    logic [COUNT_W-1:0]  cfg_count;
    logic [OFFSET_W-1:0] byte_offset;
    logic [BYTES_W-1:0]  level_bytes;
    logic                level_present;

    // Configuration registers.
    tmo_cfg_regs #(
        .DIM_BITS (DIM_BITS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg_kind   (cfg_kind),
        .cfg_fmt    (cfg_fmt),
        .cfg_width  (cfg_width),
        .cfg_height (cfg_height),
        .cfg_depth  (cfg_depth),
        .cfg_count  (cfg_count)
    );

    // Sequencing of the per-level loop.
    tmo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    // Arithmetic and result register.
    tmo_dpath #(
        .MAX_LEVELS (MAX_LEVELS),
        .DIM_BITS   (DIM_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_level      (s_tdata[3:0]),
        .in_face       (s_tdata[6:4]),
        .cfg_kind      (cfg_kind),
        .cfg_fmt       (cfg_fmt),
        .cfg_width     (cfg_width),
        .cfg_height    (cfg_height),
        .cfg_depth     (cfg_depth),
        .cfg_count     (cfg_count),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .byte_offset   (byte_offset),
        .level_bytes   (level_bytes),
        .level_present (level_present)
    );

    // Result packing.
    assign m_tdata = {2'b00, level_present, level_bytes, byte_offset};

endmodule
